[rtl/core/iec104_pkg.sv]
// Package for the IEC 104 ASDU object parser: types, codes and the per-type tables.
// Used by every module in rtl/core; depends on nothing.
package iec104_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusShort     = 2'd1;
  localparam logic [1:0] StatusUnsupport = 2'd2;
  localparam logic [1:0] StatusTruncated = 2'd3;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_ADDR   = 4'b0010,
    PH_ELEM   = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_t;

  // One request passed from the byte parser to the record builder.
  typedef struct packed {
    logic        emit_obj;
    logic        emit_end;
    logic [7:0]  type_ident;
    logic [7:0]  vsq;
    logic [7:0]  cause;
    logic [7:0]  originator;
    logic [15:0] station;
    logic [24:0] address;
    logic [95:0] elem;
    logic [1:0]  status;
  } req_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  type_ident;
    logic [7:0]  variable_qualifier;
    logic [7:0]  cause_byte;
    logic [7:0]  originator;
    logic [15:0] station_address;
    logic [24:0] object_address;
    logic [31:0] value_bits;
    logic [7:0]  qualifier;
    logic [55:0] time_tag;
    logic [1:0]  status;
    logic        last_record;
  } rec_t;

  // Element length in bytes for each decoded type; zero means not decoded.
  function automatic logic [3:0] elem_len(input logic [7:0] t);
    case (t) inside
      8'd1, 8'd3, 8'd45, 8'd46, 8'd47, 8'd70, 8'd100, 8'd105: elem_len = 4'd1;
      8'd2, 8'd4:                        elem_len = 4'd4;
      8'd9, 8'd11, 8'd48, 8'd49:         elem_len = 4'd3;
      8'd13, 8'd15, 8'd50:               elem_len = 4'd5;
      8'd103:                            elem_len = 4'd7;
      8'd30, 8'd31, 8'd58, 8'd59:        elem_len = 4'd8;
      8'd34, 8'd35, 8'd61:               elem_len = 4'd10;
      8'd36, 8'd37, 8'd63:               elem_len = 4'd12;
      default:                           elem_len = 4'd0;
    endcase
  endfunction

endpackage

[rtl/core/iec104_front.sv]
// Byte parser: tracks header, address and element phases and produces build requests.
// Depends on iec104_pkg.
module iec104_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_end_of_asdu,
  output logic                 req_valid,
  output iec104_pkg::req_t     req,
  input  logic                 req_ready
);
  import iec104_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  type_r, type_nxt, vsq_r, vsq_nxt, cause_r, cause_nxt, orig_r, orig_nxt;
  logic [15:0] station_r, station_nxt;
  logic [6:0]  done_r, done_nxt;
  logic [23:0] base_r, base_nxt, cur_r, cur_nxt;
  logic [95:0] elem_r, elem_nxt;
  logic        fin_r, fin_nxt;
  logic        acc, emit_obj, emit_end;
  logic [1:0]  status;
  logic [24:0] obj_addr;
  logic [3:0]  pos_inc;

  assign in_full = !req_ready;
  assign acc     = in_push && req_ready;
  assign pos_inc = pos_r + 4'd1;

  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; type_nxt = type_r; vsq_nxt = vsq_r;
    cause_nxt = cause_r; orig_nxt = orig_r; station_nxt = station_r; done_nxt = done_r;
    base_nxt = base_r; cur_nxt = cur_r; elem_nxt = elem_r; fin_nxt = fin_r;
    emit_obj = 1'b0;
    obj_addr = vsq_r[7] ? ({1'b0, base_r} + {18'd0, done_r}) : {1'b0, cur_r};
    case (phase_r)
      PH_HEADER: begin
        case (pos_r)
          4'd0: type_nxt = in_data_byte;
          4'd1: vsq_nxt = in_data_byte;
          4'd2: cause_nxt = in_data_byte;
          4'd3: orig_nxt = in_data_byte;
          4'd4: station_nxt = {8'd0, in_data_byte};
          default: station_nxt = {in_data_byte, station_r[7:0]};
        endcase
        pos_nxt = pos_inc;
        if (pos_inc >= 4'd6) begin
          pos_nxt = 4'd0; done_nxt = 7'd0;
          if (elem_len(type_r) == 4'd0) begin
            phase_nxt = PH_SKIP; fin_nxt = 1'b0;
          end else if (vsq_r[6:0] == 7'd0) begin
            phase_nxt = PH_SKIP; fin_nxt = 1'b1;
          end else begin
            phase_nxt = PH_ADDR;
          end
        end
      end
      PH_ADDR: begin
        case (pos_r[1:0])
          2'd0: cur_nxt = {16'd0, in_data_byte};
          2'd1: cur_nxt = {8'd0, in_data_byte, cur_r[7:0]};
          default: cur_nxt = {in_data_byte, cur_r[15:0]};
        endcase
        pos_nxt = pos_inc;
        if (pos_inc >= 4'd3) begin
          if (vsq_r[7]) base_nxt = cur_nxt;
          phase_nxt = PH_ELEM; pos_nxt = 4'd0;
        end
      end
      PH_ELEM: begin
        for (int i = 0; i < 12; i++) begin
          if (pos_r == 4'(i)) elem_nxt[8*i +: 8] = in_data_byte;
        end
        pos_nxt = pos_inc;
        if (pos_inc >= elem_len(type_r)) begin
          emit_obj = 1'b1;
          done_nxt = done_r + 7'd1;
          pos_nxt = 4'd0;
          if (done_nxt >= vsq_r[6:0]) begin
            phase_nxt = PH_SKIP; fin_nxt = 1'b1;
          end else begin
            phase_nxt = vsq_r[7] ? PH_ELEM : PH_ADDR;
          end
        end
      end
      default: ;
    endcase
    emit_end = in_end_of_asdu;
    case (phase_nxt)
      PH_HEADER: status = StatusShort;
      PH_ADDR, PH_ELEM: status = StatusTruncated;
      default: status = fin_nxt ? StatusOk : StatusUnsupport;
    endcase
    if (in_end_of_asdu) begin
      phase_nxt = PH_HEADER; pos_nxt = 4'd0; done_nxt = 7'd0; fin_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; pos_r <= '0; type_r <= '0; vsq_r <= '0; cause_r <= '0;
      orig_r <= '0; station_r <= '0; done_r <= '0; base_r <= '0; cur_r <= '0; fin_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; type_r <= type_nxt; vsq_r <= vsq_nxt;
      cause_r <= cause_nxt; orig_r <= orig_nxt; station_r <= station_nxt;
      done_r <= done_nxt; base_r <= base_nxt; cur_r <= cur_nxt; fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) elem_r <= elem_nxt;
  end

  assign req_valid      = acc && (emit_obj || emit_end);
  assign req.emit_obj   = emit_obj;
  assign req.emit_end   = emit_end;
  assign req.type_ident = type_nxt;
  assign req.vsq        = vsq_nxt;
  assign req.cause      = cause_nxt;
  assign req.originator = orig_nxt;
  assign req.station    = station_nxt;
  assign req.address    = obj_addr;
  assign req.elem       = elem_nxt;
  assign req.status     = status;
endmodule

[rtl/core/iec104_queue.sv]
// Small FIFO of build requests between the byte parser and the record builder.
// Depends on iec104_pkg.
module iec104_queue #(
  parameter int unsigned Depth = iec104_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  input  iec104_pkg::req_t wr_data,
  output logic             wr_ready,
  output logic             rd_valid,
  output iec104_pkg::req_t rd_data,
  input  logic             rd_take
);
  import iec104_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  req_t            mem_r [Depth];
  logic [Aw-1:0]   wp_r, rp_r;
  logic [Aw:0]     cnt_r;
  logic            wr, rd;

  assign wr_ready = cnt_r < (Aw+1)'(Depth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == Aw'(Depth-1)) ? '0 : wp_r + Aw'(1);
      if (rd) rp_r <= (rp_r == Aw'(Depth-1)) ? '0 : rp_r + Aw'(1);
      cnt_r <= cnt_r + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

[rtl/core/iec104_back.sv]
// Record builder: decodes queued requests into object and end records, registered output.
// Depends on iec104_pkg.
module iec104_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  iec104_pkg::req_t req,
  output logic             req_take,
  output logic             rec_valid,
  output iec104_pkg::rec_t rec,
  input  logic             rec_pop
);
  import iec104_pkg::*;

  logic        obj_done_r;  // object record of a combined request already sent
  logic        vld_r;
  rec_t        rec_r, obj_rec, end_rec, nxt_rec;
  logic        load, both;
  logic [7:0]  b [12];
  logic [15:0] u16;
  logic [31:0] u32;
  logic [95:0] e;

  assign e = req.elem;
  always_comb begin
    for (int i = 0; i < 12; i++) b[i] = e[8*i +: 8];
  end
  assign u16 = {b[1], b[0]};
  assign u32 = {b[3], b[2], b[1], b[0]};

  always_comb begin
    obj_rec = '0;
    obj_rec.type_ident = req.type_ident;
    obj_rec.variable_qualifier = req.vsq;
    obj_rec.cause_byte = req.cause;
    obj_rec.originator = req.originator;
    obj_rec.station_address = req.station;
    obj_rec.object_address = req.address;
    case (req.type_ident) inside
      8'd1, 8'd2, 8'd30, 8'd45, 8'd58: begin
        obj_rec.value_bits = {31'd0, b[0][0]}; obj_rec.qualifier = b[0];
        if (req.type_ident == 8'd2) obj_rec.time_tag = {32'd0, e[31:8]};
        else if (req.type_ident != 8'd1 && req.type_ident != 8'd45)
          obj_rec.time_tag = e[63:8];
      end
      8'd3, 8'd4, 8'd31, 8'd46, 8'd59, 8'd47: begin
        obj_rec.value_bits = {30'd0, b[0][1:0]}; obj_rec.qualifier = b[0];
        if (req.type_ident == 8'd4) obj_rec.time_tag = {32'd0, e[31:8]};
        else if (req.type_ident == 8'd31 || req.type_ident == 8'd59)
          obj_rec.time_tag = e[63:8];
      end
      8'd9, 8'd11, 8'd48, 8'd49, 8'd34, 8'd35, 8'd61: begin
        obj_rec.value_bits = {{16{u16[15]}}, u16}; obj_rec.qualifier = b[2];
        if (req.type_ident == 8'd34 || req.type_ident == 8'd35 || req.type_ident == 8'd61)
          obj_rec.time_tag = e[79:24];
      end
      8'd13, 8'd50, 8'd15, 8'd36, 8'd63, 8'd37: begin
        obj_rec.value_bits = u32; obj_rec.qualifier = b[4];
        if (req.type_ident == 8'd36 || req.type_ident == 8'd63 || req.type_ident == 8'd37)
          obj_rec.time_tag = e[95:40];
      end
      8'd70: begin
        obj_rec.value_bits = {25'd0, b[0][6:0]}; obj_rec.qualifier = b[0];
      end
      8'd100, 8'd105: obj_rec.qualifier = b[0];
      8'd103: obj_rec.time_tag = e[55:0];
      default: ;
    endcase
  end

  always_comb begin
    end_rec = '0;
    end_rec.record_kind = 1'b1;
    end_rec.status = req.status;
    end_rec.last_record = 1'b1;
    if (req.status != StatusShort) begin
      end_rec.type_ident = req.type_ident;
      end_rec.variable_qualifier = req.vsq;
      end_rec.cause_byte = req.cause;
      end_rec.originator = req.originator;
      end_rec.station_address = req.station;
    end
  end

  assign both    = req.emit_obj && req.emit_end;
  assign load    = req_valid && (!vld_r || rec_pop);
  assign nxt_rec = (req.emit_obj && !obj_done_r) ? obj_rec : end_rec;
  assign req_take = load && !(both && !obj_done_r);
  assign rec_valid = vld_r;
  assign rec = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0; obj_done_r <= 1'b0;
    end else begin
      if (load) vld_r <= 1'b1;
      else if (rec_pop) vld_r <= 1'b0;
      if (load) obj_done_r <= both && !obj_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) rec_r <= nxt_rec;
  end
endmodule

[rtl/core/iec104_asdu_object_parser.sv]
// IEC 104 ASDU object parser, top level: parser front, request queue, record builder.
// Throughput: one byte per cycle while the queue has room; records leave at one per cycle
// while pop is held and requests are queued. A record reaches the result ports through the
// queue write and then the output register. A byte that completes an object and ends the
// ASDU yields two records, the object record first. Synchronous active-low reset clears the
// parser state, the queue pointers and the output valid flag; element bytes are not reset.
module iec104_asdu_object_parser #(
  parameter int unsigned QueueDepth = iec104_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_asdu,
  output logic        empty,
  input  logic        pop,
  output logic        out_record_kind,
  output logic [7:0]  out_type_ident,
  output logic [7:0]  out_variable_qualifier,
  output logic [7:0]  out_cause_byte,
  output logic [7:0]  out_originator,
  output logic [15:0] out_station_address,
  output logic [24:0] out_object_address,
  output logic signed [31:0] out_value_bits,
  output logic [7:0]  out_qualifier,
  output logic [55:0] out_time_tag,
  output logic [1:0]  out_status,
  output logic        out_last_record
);
  import iec104_pkg::*;

  // The front accepts a byte whenever the queue has room, so the parser state
  // advances on each accepted byte; each queued request holds one or two records.
  logic  f_valid, f_ready, q_valid, q_take, r_valid;
  req_t  f_req, q_req;
  rec_t  r;

  iec104_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_data_byte, .in_end_of_asdu,
    .req_valid(f_valid), .req(f_req), .req_ready(f_ready)
  );

  iec104_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_data(f_req), .wr_ready(f_ready),
    .rd_valid(q_valid), .rd_data(q_req), .rd_take(q_take)
  );

  // The builder holds each record in a register until it is popped.
  iec104_back u_back (
    .clk, .rst_n, .req_valid(q_valid), .req(q_req), .req_take(q_take),
    .rec_valid(r_valid), .rec(r), .rec_pop(pop)
  );

  assign empty                  = !r_valid;
  assign out_record_kind        = r.record_kind;
  assign out_type_ident         = r.type_ident;
  assign out_variable_qualifier = r.variable_qualifier;
  assign out_cause_byte         = r.cause_byte;
  assign out_originator         = r.originator;
  assign out_station_address    = r.station_address;
  assign out_object_address     = r.object_address;
  assign out_value_bits         = r.value_bits;
  assign out_qualifier          = r.qualifier;
  assign out_time_tag           = r.time_tag;
  assign out_status             = r.status;
  assign out_last_record        = r.last_record;
endmodule

[rtl/core/iec104_checker.sv]
// Port-level checker for the ASDU object parser, bound to the top level.
// Depends on iec104_pkg and iec104_asdu_object_parser.
module iec104_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic        out_record_kind,
  input logic        out_last_record,
  input logic [1:0]  out_status,
  input logic [24:0] out_object_address,
  input logic [15:0] out_station_address
);
  import iec104_pkg::*;

  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_record_kind == out_last_record)) else $error("kind/last mismatch");

  a_obj_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_record_kind) |-> (out_status == StatusOk)) else $error("object status");

  a_end_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_record_kind) |-> (out_object_address == '0)) else $error("end address");

  a_short_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_record_kind && out_status == StatusShort) |-> (out_station_address == '0))
    else $error("short header");

  // A waiting result stays on the ports until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_record_kind) && $stable(out_status) &&
                          $stable(out_object_address) && $stable(out_station_address)))
    else $error("result changed while waiting");
endmodule

bind iec104_asdu_object_parser iec104_checker u_checker (
  .clk, .rst_n, .empty, .pop, .out_record_kind, .out_last_record, .out_status,
  .out_object_address, .out_station_address
);

[tb/iec104_asdu_object_parser_tb.sv]
// Testbench for the IEC 104 ASDU object parser: byte stream in, object and end records out.
// A scoreboard class predicts every record from the accepted bytes and checks each popped one.
// Depends on iec104_pkg for the status codes and on the parser RTL.
module iec104_asdu_object_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iec104_pkg::*;

  // A record as the block presents it, one field per port.
  typedef struct packed {
    logic        kind;
    logic [7:0]  type_ident;
    logic [7:0]  vsq;
    logic [7:0]  cause;
    logic [7:0]  originator;
    logic [15:0] station;
    logic [24:0] address;
    logic [31:0] value;
    logic [7:0]  qualifier;
    logic [55:0] time_tag;
    logic [1:0]  status;
    logic        last;
  } record_t;

  // Predicts the records that each accepted byte causes and checks the popped records
  // against the oldest prediction.
  class asdu_record_scoreboard;
    phase_t      phase;
    int unsigned pos;
    logic [7:0]  h_type, h_vsq, h_cause, h_orig;
    logic [15:0] h_station;
    logic [6:0]  done_count;
    logic [23:0] base_addr, cur_addr;
    logic [7:0]  elem[12];
    bit          finished;
    record_t     pending_records[$];
    int unsigned mismatches;

    function new();
      phase = PH_HEADER;
      pos = 0;
      h_type = 0; h_vsq = 0; h_cause = 0; h_orig = 0; h_station = 0;
      done_count = 0; base_addr = 0; cur_addr = 0; finished = 0;
      mismatches = 0;
      foreach (elem[i]) elem[i] = 0;
    endfunction

    function int unsigned element_length(logic [7:0] t);
      case (t)
        1, 3, 45, 46, 47, 70, 100, 105: return 1;
        2, 4: return 4;
        9, 11, 48, 49: return 3;
        13, 15, 50: return 5;
        103: return 7;
        30, 31, 58, 59: return 8;
        34, 35, 61: return 10;
        36, 37, 63: return 12;
        default: return 0;
      endcase
    endfunction

    function logic [55:0] tag_from(int unsigned off, int unsigned len);
      logic [55:0] v;
      v = 0;
      for (int unsigned i = 0; i < len && off + i < 12; i++) v |= 56'(elem[off + i]) << (8 * i);
      return v;
    endfunction

    function record_t object_record(logic [24:0] addr);
      record_t r;
      logic [15:0] u16;
      r = '0;
      u16 = {elem[1], elem[0]};
      r.type_ident = h_type; r.vsq = h_vsq; r.cause = h_cause;
      r.originator = h_orig; r.station = h_station; r.address = addr;
      case (h_type)
        1, 2, 30, 45, 58: begin
          r.value = 32'(elem[0][0]); r.qualifier = elem[0];
          if (h_type == 2) r.time_tag = tag_from(1, 3);
          else if (h_type != 1 && h_type != 45) r.time_tag = tag_from(1, 7);
        end
        3, 4, 31, 46, 59, 47: begin
          r.value = 32'(elem[0][1:0]); r.qualifier = elem[0];
          if (h_type == 4) r.time_tag = tag_from(1, 3);
          else if (h_type == 31 || h_type == 59) r.time_tag = tag_from(1, 7);
        end
        9, 11, 48, 49, 34, 35, 61: begin
          r.value = {{16{u16[15]}}, u16}; r.qualifier = elem[2];
          if (h_type == 34 || h_type == 35 || h_type == 61) r.time_tag = tag_from(3, 7);
        end
        13, 50, 15, 36, 63, 37: begin
          r.value = {elem[3], elem[2], u16}; r.qualifier = elem[4];
          if (h_type == 36 || h_type == 63 || h_type == 37) r.time_tag = tag_from(5, 7);
        end
        70: begin
          r.value = 32'(elem[0][6:0]); r.qualifier = elem[0];
        end
        100, 105: r.qualifier = elem[0];
        103: r.time_tag = tag_from(0, 7);
        default: ;
      endcase
      return r;
    endfunction

    // Notes one accepted byte and queues the records it causes.
    function void note_byte(logic [7:0] b, logic last_byte);
      record_t r;
      logic [1:0] st;
      bit sq;
      int unsigned len;
      sq = h_vsq[7];
      case (phase)
        PH_HEADER: begin
          case (pos)
            0: h_type = b;
            1: h_vsq = b;
            2: h_cause = b;
            3: h_orig = b;
            4: h_station = {8'd0, b};
            default: h_station[15:8] = b;
          endcase
          pos++;
          if (pos >= 6) begin
            pos = 0;
            done_count = 0;
            if (element_length(h_type) == 0) begin
              phase = PH_SKIP; finished = 0;
            end else if (h_vsq[6:0] == 0) begin
              phase = PH_SKIP; finished = 1;
            end else begin
              phase = PH_ADDR;
            end
          end
        end
        PH_ADDR: begin
          if (pos == 0) cur_addr = 0;
          cur_addr |= 24'(b) << (8 * pos);
          pos++;
          if (pos >= 3) begin
            if (sq) base_addr = cur_addr;
            phase = PH_ELEM;
            pos = 0;
          end
        end
        PH_ELEM: begin
          len = element_length(h_type);
          if (pos < 12) elem[pos] = b;
          pos++;
          if (pos >= len) begin
            pending_records = {pending_records,
                               object_record(sq ? 25'(base_addr) + 25'(done_count)
                                                : 25'(cur_addr))};
            done_count = done_count + 7'd1;
            pos = 0;
            if (done_count >= h_vsq[6:0]) begin
              phase = PH_SKIP; finished = 1;
            end else begin
              phase = sq ? PH_ELEM : PH_ADDR;
            end
          end
        end
        default: ;
      endcase
      if (last_byte) begin
        if (phase == PH_HEADER) st = StatusShort;
        else if (phase == PH_ADDR || phase == PH_ELEM) st = StatusTruncated;
        else st = finished ? StatusOk : StatusUnsupport;
        r = '0;
        r.kind = 1'b1;
        r.status = st;
        r.last = 1'b1;
        if (st != StatusShort) begin
          r.type_ident = h_type; r.vsq = h_vsq; r.cause = h_cause;
          r.originator = h_orig; r.station = h_station;
        end
        pending_records = {pending_records, r};
        phase = PH_HEADER;
        pos = 0;
        done_count = 0;
        finished = 0;
      end
    endfunction

    // Checks one popped record against the oldest prediction.
    function void check_record(record_t got);
      record_t exp_rec;
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected record %h", got);
        return;
      end
      exp_rec = pending_records.pop_front();
      if (got !== exp_rec) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: record mismatch");
          $display("  expected kind=%0d type=%0d vsq=%h cot=%h org=%h ca=%h", exp_rec.kind,
                   exp_rec.type_ident, exp_rec.vsq, exp_rec.cause, exp_rec.originator,
                   exp_rec.station);
          $display("           ioa=%h val=%h q=%h tag=%h st=%0d last=%0d", exp_rec.address,
                   exp_rec.value, exp_rec.qualifier, exp_rec.time_tag, exp_rec.status,
                   exp_rec.last);
          $display("  actual   kind=%0d type=%0d vsq=%h cot=%h org=%h ca=%h", got.kind,
                   got.type_ident, got.vsq, got.cause, got.originator, got.station);
          $display("           ioa=%h val=%h q=%h tag=%h st=%0d last=%0d", got.address,
                   got.value, got.qualifier, got.time_tag, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_asdu = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_record_kind;
  logic [7:0]  out_type_ident, out_variable_qualifier, out_cause_byte, out_originator;
  logic [15:0] out_station_address;
  logic [24:0] out_object_address;
  logic signed [31:0] out_value_bits;
  logic [7:0]  out_qualifier;
  logic [55:0] out_time_tag;
  logic [1:0]  out_status;
  logic        out_last_record;

  // Idle percentages for the sender and the receiver; changed between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned byte_count = 0;

  asdu_record_scoreboard sb = new();

  // Supported types, so that most random ASDUs get past the header.
  byte unsigned known_types[$] = '{1, 2, 3, 4, 9, 11, 13, 15, 30, 31, 34, 35, 36, 37, 45, 46,
                                   47, 48, 49, 50, 58, 59, 61, 63, 70, 100, 103, 105};

  iec104_asdu_object_parser dut (
    .clk, .rst_n, .push, .full, .in_data_byte, .in_end_of_asdu, .empty, .pop,
    .out_record_kind, .out_type_ident, .out_variable_qualifier, .out_cause_byte,
    .out_originator, .out_station_address, .out_object_address, .out_value_bits,
    .out_qualifier, .out_time_tag, .out_status, .out_last_record
  );

  always #5 clk = ~clk;

  // Result side: a record is taken at a rising edge with pop high and empty low. Pop is
  // redrawn at every falling edge from the current stall rate.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      sb.check_record({out_record_kind, out_type_ident, out_variable_qualifier, out_cause_byte,
                       out_originator, out_station_address, out_object_address,
                       out_value_bits, out_qualifier, out_time_tag, out_status,
                       out_last_record});
    end
  end

  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one byte as a request: waits out the random gap, holds push until accepted.
  // Push stays high afterwards so that bytes can follow back to back.
  task automatic send_byte(input logic [7:0] b, input logic last_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_end_of_asdu <= last_byte;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(b, last_byte);
    byte_count++;
    @(negedge clk);
  endtask

  // Sends a whole ASDU held in a queue; the final byte carries the end flag.
  task automatic send_asdu(input byte unsigned bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Stops sending and waits until every predicted record has been popped, then a few
  // cycles more.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending_records.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Builds a random ASDU of the given type. Count is kept small, with a rare large count
  // on one-byte elements; the cut point decides whether it ends cleanly, carries trailing
  // bytes or is truncated.
  task automatic random_asdu(input byte unsigned t);
    byte unsigned a[$];
    int unsigned cnt, len, total;
    bit sq;
    len = sb.element_length(t);
    cnt = $urandom_range(4);
    if (len == 1 && $urandom_range(9) == 0) cnt = $urandom_range(127);
    sq = $urandom_range(1);
    a = {t, byte'({sq, 7'(cnt)}), byte'($urandom), byte'($urandom), byte'($urandom),
         byte'($urandom)};
    total = sq ? (cnt ? 3 + cnt * len : 0) : cnt * (3 + len);
    if (len == 0) total = $urandom_range(5);
    case ($urandom_range(9))
      0: total = total + $urandom_range(1, 3);
      1: if (total > 0) total = $urandom_range(total - 1);
      default: ;
    endcase
    repeat (total) a = {a, byte'($urandom)};
    if ($urandom_range(29) == 0) a = a[0:$urandom_range(4)];
    send_asdu(a);
  endtask

  initial begin
    byte unsigned t;
    int unsigned phase_end;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: short ASDU, zero count, unsupported type, sequence mode with the
    // largest address, element lengths of 1, 7, 10 and 12 bytes, truncation, trailing bytes.
    send_byte(8'hFF, 1'b1);
    send_asdu('{1, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h12});
    send_asdu('{8'hFF, 8'h81, 8'h40, 8'h01, 8'h00, 8'h00, 8'h55, 8'h55});
    send_asdu('{1, 8'h82, 8'hC3, 8'hAA, 8'h34, 8'h12, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00});
    send_asdu('{35, 8'h01, 8'h03, 8'h00, 8'h01, 8'h00, 8'h01, 8'h02, 8'h03, 8'h00, 8'h80,
                8'hF1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_asdu('{37, 8'h01, 8'h03, 8'h00, 8'h01, 8'h00, 8'h01, 8'h02, 8'h03, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_asdu('{103, 8'h01, 8'h06, 8'h00, 8'h01, 8'h00, 8'h05, 8'h00, 8'h00, 8'h11, 8'h22});
    drain();

    // Random part over the idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      phase_end = byte_count + 95;
      while (byte_count < phase_end) begin
        if ($urandom_range(9) == 0) t = byte'($urandom);
        else t = known_types[$urandom_range(known_types.size() - 1)];
        random_asdu(t);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_records.size() == 0) begin
      $display("iec104_asdu_object_parser verification clean");
    end else begin
      $display("iec104_asdu_object_parser verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("iec104_asdu_object_parser verification failed");
    $finish;
  end

endmodule
